// ===== sv/ppm_sum_frame_decoder_assert.svh =====
// Assertion macros shared by the PPM-sum frame decoder modules.
// Needs signals clk and rst_n in the module that uses a macro.
`ifndef PPM_SUM_FRAME_DECODER_ASSERT_SVH
`define PPM_SUM_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/psfd_pkg.sv =====
// Package of the PPM-sum frame decoder: constants, register indexes,
// controller state type and the command/status structs. No dependencies.
`default_nettype none

package psfd_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] SYNC_WIDTH_RST       = 16'd2700;
    localparam logic [15:0] PULSE_LOW_LIMIT_RST  = 16'd700;
    localparam logic [15:0] PULSE_HIGH_LIMIT_RST = 16'd2300;
    localparam logic [4:0]  MIN_CHANNELS_RST     = 5'd5;

    typedef enum logic [1:0] {
        REG_SYNC_WIDTH       = 2'd0,
        REG_PULSE_LOW_LIMIT  = 2'd1,
        REG_PULSE_HIGH_LIMIT = 2'd2,
        REG_MIN_CHANNELS     = 2'd3
    } psfd_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } psfd_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // take the pulse word on the input channel
        logic rd;       // read the capture buffer at the publish index
        logic load;     // load the output register and advance the index
    } psfd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic pub;      // the offered pulse word completes a frame
        logic last;     // publish index points at the final channel
        logic out_free; // output register can take a word this cycle
    } psfd_sts_t;

endpackage

`default_nettype wire

// ===== sv/psfd_if.sv =====
// Handshake channels of the PPM-sum frame decoder: pulse input and channel output.
// Depends on nothing.
`default_nettype none

interface psfd_pulse_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink (input valid, input pulse_width, output ready);
endinterface

interface psfd_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic [4:0]  channel_total;
    logic [15:0] frame_number;
    logic        last;

    modport source (
        output valid, output channel_index, output channel_value,
        output channel_total, output frame_number, output last, input ready
    );
    modport sink (
        input valid, input channel_index, input channel_value,
        input channel_total, input frame_number, input last, output ready
    );
endinterface

`default_nettype wire

// ===== sv/psfd_regs.sv =====
// APB configuration registers of the PPM-sum frame decoder.
// Depends on psfd_pkg.
`default_nettype none

module psfd_regs
    import psfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [15:0]           sync_width,
    output logic      [15:0]           pulse_low_limit,
    output logic      [15:0]           pulse_high_limit,
    output logic      [4:0]            min_channels
);

    logic [15:0]   sync_width_reg;
    logic [15:0]   pulse_low_limit_reg;
    logic [15:0]   pulse_high_limit_reg;
    logic [4:0]    min_channels_reg;
    logic          wr_en;
    psfd_reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = psfd_reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_width_reg       <= SYNC_WIDTH_RST;
            pulse_low_limit_reg  <= PULSE_LOW_LIMIT_RST;
            pulse_high_limit_reg <= PULSE_HIGH_LIMIT_RST;
            min_channels_reg     <= MIN_CHANNELS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SYNC_WIDTH:       sync_width_reg       <= pwdata[15:0];
                REG_PULSE_LOW_LIMIT:  pulse_low_limit_reg  <= pwdata[15:0];
                REG_PULSE_HIGH_LIMIT: pulse_high_limit_reg <= pwdata[15:0];
                REG_MIN_CHANNELS:     min_channels_reg     <= pwdata[4:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SYNC_WIDTH:       prdata = APB_DATA_W'(sync_width_reg);
            REG_PULSE_LOW_LIMIT:  prdata = APB_DATA_W'(pulse_low_limit_reg);
            REG_PULSE_HIGH_LIMIT: prdata = APB_DATA_W'(pulse_high_limit_reg);
            REG_MIN_CHANNELS:     prdata = APB_DATA_W'(min_channels_reg);
            default:              prdata = '0;
        endcase
    end

    assign sync_width       = sync_width_reg;
    assign pulse_low_limit  = pulse_low_limit_reg;
    assign pulse_high_limit = pulse_high_limit_reg;
    assign min_channels     = min_channels_reg;

endmodule

`default_nettype wire

// ===== sv/psfd_ctrl.sv =====
// Controller of the PPM-sum frame decoder: sequences pulse intake and publishing.
// Depends on psfd_pkg and ppm_sum_frame_decoder_assert.svh.
`default_nettype none
`include "ppm_sum_frame_decoder_assert.svh"

module psfd_ctrl
    import psfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire psfd_sts_t sts,
    output psfd_cmd_t      cmd
);

    psfd_state_t state_reg;
    psfd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && sts.pub)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PSFD_ASSERT_NEXT(a_read_then_load, state_reg == ST_READ, state_reg == ST_LOAD, "read not followed by load")
    `PSFD_ASSERT_NEXT(a_pub_starts_read, cmd.accept && sts.pub, state_reg == ST_READ, "frame end did not start publishing")
    `PSFD_ASSERT_NOW(a_load_needs_room, cmd.load, sts.out_free, "output register loaded while full")

endmodule

`default_nettype wire

// ===== sv/psfd_dp.sv =====
// Datapath of the PPM-sum frame decoder: sync/capture decision, capture buffer,
// frame counter and output register. Depends on psfd_pkg and the assertion header.
`default_nettype none
`include "ppm_sum_frame_decoder_assert.svh"

module psfd_dp
    import psfd_pkg::*;
#(
    parameter  int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int PosW         = $clog2(MAX_CHANNELS + 1),
    localparam int IdxW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire psfd_cmd_t   cmd,
    output psfd_sts_t        sts,
    input  wire logic [15:0] pulse_width,
    input  wire logic [15:0] sync_width,
    input  wire logic [15:0] pulse_low_limit,
    input  wire logic [15:0] pulse_high_limit,
    input  wire logic [4:0]  min_channels,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [3:0]       channel_index,
    output logic [15:0]      channel_value,
    output logic [4:0]       channel_total,
    output logic [15:0]      frame_number,
    output logic             last
);

    logic [15:0]     mem [MAX_CHANNELS];

    logic            synced_reg,  synced_next;
    logic [PosW-1:0] pos_reg,     pos_next;
    logic [15:0]     frame_reg,   frame_next;
    logic [PosW-1:0] total_reg,   total_next;
    logic [IdxW-1:0] rd_idx_reg,  rd_idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     rd_data_reg;
    logic [3:0]      index_reg;
    logic [15:0]     value_reg;
    logic [4:0]      total_out_reg;
    logic [15:0]     frame_out_reg;
    logic            last_reg;

    logic            is_sync;
    logic            in_band;
    logic            capt;
    logic            full;
    logic            pub_sync;
    logic            is_last;

    assign is_sync  = pulse_width >= sync_width;
    assign in_band  = (pulse_width > pulse_low_limit) && (pulse_width < pulse_high_limit);
    assign capt     = !is_sync && synced_reg && in_band && (32'(pos_reg) < MAX_CHANNELS);
    assign full     = capt && (pos_reg == PosW'(MAX_CHANNELS - 1));
    assign pub_sync = is_sync && synced_reg && (pos_reg != '0)
                      && (32'(pos_reg) >= 32'(min_channels));
    assign is_last  = (32'(rd_idx_reg) + 32'd1) == 32'(total_reg);

    assign sts.pub      = pub_sync || full;
    assign sts.last     = is_last;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        synced_next    = synced_reg;
        pos_next       = pos_reg;
        frame_next     = frame_reg;
        total_next     = total_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.accept)
        begin
            priority if (is_sync)
            begin
                synced_next = 1'b1;
                pos_next    = '0;
            end
            else if (full)
            begin
                // buffer full: publish now and wait for the next sync
                synced_next = 1'b0;
                pos_next    = '0;
            end
            else if (capt)
            begin
                pos_next = pos_reg + PosW'(1);
            end
            else
            begin
                // short pulse outside the window or while unsynchronized: drop it
            end
            if (pub_sync || full)
            begin
                frame_next  = frame_reg + 16'd1;
                total_next  = full ? PosW'(MAX_CHANNELS) : pos_reg;
                rd_idx_next = '0;
            end
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            rd_idx_next    = rd_idx_reg + IdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg    <= 1'b0;
            pos_reg       <= '0;
            frame_reg     <= '0;
            total_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            synced_reg    <= synced_next;
            pos_reg       <= pos_next;
            frame_reg     <= frame_next;
            total_reg     <= total_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && capt)
        begin
            mem[pos_reg[IdxW-1:0]] <= pulse_width;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            index_reg     <= 4'(rd_idx_reg);
            value_reg     <= rd_data_reg;
            total_out_reg <= 5'(total_reg);
            frame_out_reg <= frame_reg;
            last_reg      <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign channel_total = total_out_reg;
    assign frame_number  = frame_out_reg;
    assign last          = last_reg;

    `PSFD_ASSERT_NOW(a_unsynced_empty, !synced_reg, pos_reg == '0, "channels held while unsynchronized")
    `PSFD_ASSERT_NOW(a_pos_in_range, 1'b1, 32'(pos_reg) < MAX_CHANNELS, "channel position overran buffer")
    `PSFD_ASSERT_NOW(a_load_in_frame, cmd.load, 32'(rd_idx_reg) < 32'(total_reg), "publish index beyond frame")

endmodule

`default_nettype wire

// ===== sv/ppm_sum_frame_decoder.sv =====
// Top level of the PPM-sum frame decoder: APB registers, controller, datapath.
// Depends on psfd_pkg, psfd_if, psfd_regs, psfd_ctrl and psfd_dp.
`default_nettype none

// PPM-sum frame decoder. Each word on the pulse channel is one measured pulse
// width in microseconds. A pulse at or above sync_width ends a frame; if the
// decoder was synchronized and at least min_channels (and at least one)
// channels were captured, the frame is published. Either way the decoder is
// then synchronized with an empty frame. While synchronized, a pulse strictly
// between pulse_low_limit and pulse_high_limit is captured as the next
// channel; other short pulses are dropped, and all short pulses are dropped
// while unsynchronized. Capturing MAX_CHANNELS channels publishes the frame
// at once and drops sync until the next sync pulse. Publishing emits one word
// per channel on the channel output, in channel order, carrying the channel
// index, its width, the frame's channel total, the frame number (count of
// published frames, wrapping at 16 bits) and last on the final channel.
// Timing: a pulse that does not end a frame is taken as soon as it is offered,
// and the decoder is ready for the next pulse at once. A pulse that publishes
// a frame holds the pulse input while the frame goes out: for each channel the
// controller does the registered read of the capture buffer (ST_READ), then
// loads the output register (ST_LOAD), waiting while it is still full. The
// output register lets the last word of a frame wait for its taker while the
// next pulse is already accepted. Registers (APB, byte address 4*index):
// 0 sync_width (reset 2700), 1 pulse_low_limit (700), 2 pulse_high_limit
// (2300), 3 min_channels (5 bits, 5). Write them only while the block is idle.

module ppm_sum_frame_decoder
    import psfd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    psfd_pulse_if.sink                 pulse,
    psfd_chan_if.source                chan
);

    logic [15:0] sync_width;
    logic [15:0] pulse_low_limit;
    logic [15:0] pulse_high_limit;
    logic [4:0]  min_channels;
    psfd_cmd_t   cmd;
    psfd_sts_t   sts;

    // configuration registers
    psfd_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .sync_width       (sync_width),
        .pulse_low_limit  (pulse_low_limit),
        .pulse_high_limit (pulse_high_limit),
        .min_channels     (min_channels)
    );

    // sequencing: accept pulses, then walk the captured frame out
    psfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pulse.valid),
        .in_ready (pulse.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // decision logic, capture buffer and output register
    psfd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .pulse_width      (pulse.pulse_width),
        .sync_width       (sync_width),
        .pulse_low_limit  (pulse_low_limit),
        .pulse_high_limit (pulse_high_limit),
        .min_channels     (min_channels),
        .out_ready        (chan.ready),
        .out_valid        (chan.valid),
        .channel_index    (chan.channel_index),
        .channel_value    (chan.channel_value),
        .channel_total    (chan.channel_total),
        .frame_number     (chan.frame_number),
        .last             (chan.last)
    );

endmodule

`default_nettype wire
